FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the priority inheritance table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/pit_pkg.sv
// Shared command codes, status codes and controller interface types.
package pit_pkg;

   localparam logic CMD_BLOCK   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [1:0] STATUS_WRITE     = 2'd0;
   localparam logic [1:0] STATUS_NO_CHANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_IGNORED   = 2'd3;

   typedef struct packed {
      logic load;
      logic scan_en;
      logic recomp;
      logic decide;
      logic finish_recomp;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic ignored;
      logic need_recomp;
      logic out_free;
   } ctl_sts_type;

endpackage

FILE: rtl/core/pit_controller.sv
// Sequencing state machine for the priority inheritance table.
module pit_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pit_pkg::ctl_sts_type ctl_sts,
   output pit_pkg::ctl_cmd_type ctl_cmd
);
   import pit_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_RECOMP,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl_cmd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl_cmd.load = 1'b1;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ctl_cmd.scan_en = 1'b1;
            if (ctl_sts.ignored || ctl_sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            ctl_cmd.decide = 1'b1;
            state_in       = ctl_sts.need_recomp ? ST_RECOMP : ST_FINISH;
         end
         ST_RECOMP: begin
            ctl_cmd.scan_en = 1'b1;
            ctl_cmd.recomp  = 1'b1;
            if (ctl_sts.scan_done) begin
               ctl_cmd.finish_recomp = 1'b1;
               state_in              = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (ctl_sts.out_free) begin
               ctl_cmd.out_load = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/pit_datapath.sv
// Lock table storage, scan pipeline, boost decision and result register.
module pit_datapath #(
   parameter int ENTRIES        = 128,
   parameter int KEY_BITS       = 32,
   parameter int THREAD_ID_BITS = 16,
   parameter int PRIO_BITS      = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pit_pkg::ctl_cmd_type      ctl_cmd,
   output pit_pkg::ctl_sts_type      ctl_sts,
   input  logic                      in_cmd,
   input  logic [KEY_BITS-1:0]       in_key,
   input  logic [THREAD_ID_BITS-1:0] in_owner,
   input  logic [PRIO_BITS-1:0]      in_oprio,
   input  logic [PRIO_BITS-1:0]      in_obase,
   input  logic                      in_ots,
   input  logic                      in_wvalid,
   input  logic [PRIO_BITS-1:0]      in_wprio,
   input  logic                      in_wts,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [1:0]                out_status,
   output logic                      out_write,
   output logic [THREAD_ID_BITS-1:0] out_target,
   output logic [PRIO_BITS-1:0]      out_prio
);
   import pit_pkg::*;

   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(ENTRIES);

   typedef struct packed {
      logic [KEY_BITS-1:0]       key;
      logic [THREAD_ID_BITS-1:0] owner;
      logic [PRIO_BITS-1:0]      inh;
   } entry_type;

   logic                      cmd_ff;
   logic [KEY_BITS-1:0]       key_ff;
   logic [THREAD_ID_BITS-1:0] owner_ff;
   logic [PRIO_BITS-1:0]      oprio_ff;
   logic [PRIO_BITS-1:0]      obase_ff;
   logic                      ots_ff;
   logic                      wvalid_ff;
   logic [PRIO_BITS-1:0]      wprio_ff;
   logic                      wts_ff;

   entry_type                 mem [ENTRIES];
   entry_type                 rd_ff;
   logic [ENTRIES-1:0]        valid_ff;

   logic [CNT_BITS-1:0]       addr_ff;
   logic                      pend_ff;
   logic [IDX_BITS-1:0]       pidx_ff;
   logic                      found_ff;
   logic [IDX_BITS-1:0]       slot_ff;
   entry_type                 hit_ff;
   logic                      free_found_ff;
   logic [IDX_BITS-1:0]       free_ff;
   logic [PRIO_BITS-1:0]      best_ff;

   logic [1:0]                res_status_ff;
   logic                      res_write_ff;
   logic [THREAD_ID_BITS-1:0] res_target_ff;
   logic [PRIO_BITS-1:0]      res_prio_ff;

   logic                      out_valid_ff;
   logic [1:0]                out_status_ff;
   logic                      out_write_ff;
   logic [THREAD_ID_BITS-1:0] out_target_ff;
   logic [PRIO_BITS-1:0]      out_prio_ff;

   logic                      addr_live;
   logic [IDX_BITS-1:0]       addr_idx;
   logic [IDX_BITS-1:0]       rd_addr;
   logic                      scan_end;
   logic                      hit_now;
   logic                      better_now;
   logic                      ignored;
   logic                      is_block;
   logic                      table_ok;
   logic                      alloc;
   logic                      boost;
   entry_type                 cur;
   entry_type                 wr_entry;
   logic [IDX_BITS-1:0]       tgt_slot;
   logic                      mem_we;

   assign addr_live  = (addr_ff != LAST_CNT);
   assign addr_idx   = addr_ff[IDX_BITS-1:0];
   assign rd_addr    = addr_live ? addr_idx : '0;
   assign scan_end   = !addr_live && !pend_ff;
   assign hit_now    = pend_ff && valid_ff[pidx_ff] && (rd_ff.key == key_ff);
   assign better_now = pend_ff && valid_ff[pidx_ff] && (rd_ff.owner == hit_ff.owner)
                       && (rd_ff.inh != '0) && (rd_ff.inh < best_ff);

   assign is_block = (cmd_ff == CMD_BLOCK);
   assign ignored  = is_block && (!wvalid_ff || (owner_ff == '0));
   assign table_ok = found_ff || free_found_ff;
   assign alloc    = !found_ff && free_found_ff;
   assign tgt_slot = found_ff ? slot_ff : free_ff;

   always_comb begin
      if (found_ff) begin
         cur = hit_ff;
      end else begin
         cur.key   = key_ff;
         cur.owner = owner_ff;
         cur.inh   = '0;
      end
   end

   assign boost = wts_ff && ots_ff && (wprio_ff < oprio_ff)
                  && ((cur.inh == '0) || (wprio_ff < cur.inh));

   always_comb begin
      wr_entry     = cur;
      wr_entry.inh = boost ? wprio_ff : cur.inh;
   end

   assign mem_we = ctl_cmd.decide && is_block && !ignored && table_ok && (alloc || boost);

   assign ctl_sts.scan_done   = scan_end || (!ctl_cmd.recomp && hit_now);
   assign ctl_sts.ignored     = ignored;
   assign ctl_sts.need_recomp = (cmd_ff == CMD_RELEASE) && found_ff
                                && (hit_ff.owner != '0) && (hit_ff.inh != '0);
   assign ctl_sts.out_free    = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         cmd_ff    <= in_cmd;
         key_ff    <= in_key;
         owner_ff  <= in_owner;
         oprio_ff  <= in_oprio;
         obase_ff  <= in_obase;
         ots_ff    <= in_ots;
         wvalid_ff <= in_wvalid;
         wprio_ff  <= in_wprio;
         wts_ff    <= in_wts;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tgt_slot] <= wr_entry;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         addr_ff       <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (ctl_cmd.load || ctl_cmd.decide) begin
            addr_ff <= '0;
            pend_ff <= 1'b0;
         end else if (ctl_cmd.scan_en) begin
            if (addr_live) begin
               addr_ff <= addr_ff + 1'b1;
               pend_ff <= 1'b1;
            end else begin
               pend_ff <= 1'b0;
            end
         end
         if (ctl_cmd.load) begin
            found_ff      <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (ctl_cmd.scan_en && !ctl_cmd.recomp) begin
            if (hit_now) begin
               found_ff <= 1'b1;
            end
            if (addr_live && !free_found_ff && !valid_ff[addr_idx]) begin
               free_found_ff <= 1'b1;
            end
         end
         if (ctl_cmd.decide) begin
            if (is_block && !ignored && alloc) begin
               valid_ff[free_ff] <= 1'b1;
            end else if (!is_block && found_ff) begin
               valid_ff[slot_ff] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.scan_en && addr_live) begin
         pidx_ff <= addr_idx;
      end
      if (ctl_cmd.scan_en && !ctl_cmd.recomp) begin
         if (hit_now) begin
            slot_ff <= pidx_ff;
            hit_ff  <= rd_ff;
         end
         if (addr_live && !free_found_ff && !valid_ff[addr_idx]) begin
            free_ff <= addr_idx;
         end
      end
      if (ctl_cmd.decide) begin
         best_ff <= obase_ff;
      end else if (ctl_cmd.scan_en && ctl_cmd.recomp && better_now) begin
         best_ff <= rd_ff.inh;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.decide) begin
         res_status_ff <= STATUS_IGNORED;
         res_write_ff  <= 1'b0;
         res_target_ff <= '0;
         res_prio_ff   <= '0;
         if (is_block) begin
            if (ignored) begin
               res_status_ff <= STATUS_IGNORED;
            end else if (!table_ok) begin
               res_status_ff <= STATUS_FULL;
            end else if (boost) begin
               res_status_ff <= STATUS_WRITE;
               res_write_ff  <= 1'b1;
               res_target_ff <= owner_ff;
               res_prio_ff   <= wprio_ff;
            end else begin
               res_status_ff <= STATUS_NO_CHANGE;
               res_target_ff <= owner_ff;
            end
         end else if (found_ff) begin
            res_status_ff <= STATUS_NO_CHANGE;
            res_target_ff <= hit_ff.owner;
         end
      end else if (ctl_cmd.finish_recomp) begin
         res_status_ff <= STATUS_WRITE;
         res_write_ff  <= 1'b1;
         res_target_ff <= hit_ff.owner;
         res_prio_ff   <= best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl_cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_write_ff  <= res_write_ff;
         out_target_ff <= res_target_ff;
         out_prio_ff   <= res_prio_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_status = out_status_ff;
   assign out_write  = out_write_ff;
   assign out_target = out_target_ff;
   assign out_prio   = out_prio_ff;

endmodule

FILE: rtl/core/priority_inheritance_table_unit.sv
// Top level of the priority inheritance table: stream ports, controller and datapath.
//
//   Channel  Dir  Beat carries
//   req_     in   tuser: cmd; tdata: lock key, owner, priorities, class and waiter flags
//   rsp_     out  tuser: status; tdata: write flag, target owner, new priority
//
// A beat whose block command has no waiter or no owner skips the table scan.
// Other beats are bound by the one-entry-per-cycle scan of the lock table
// memory; a release that drops a boost adds a second full scan of the table
// to recompute the owner's priority.
// Reset clears all valid bits at once; no clearing pass is needed.
// A finished result waits in the output register while the next beat is taken.
`include "assert_macros.svh"

module priority_inheritance_table_unit #(
   parameter int ENTRIES        = 128,
   parameter int KEY_BITS       = 32,
   parameter int THREAD_ID_BITS = 16,
   parameter int PRIO_BITS      = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [0] cmd
   input  logic                     req_tuser,
   // lock_key, owner_id, owner_priority, owner_base_priority, owner_timeshare,
   // waiter_valid, waiter_priority, waiter_timeshare, zero fill
   input  logic [((KEY_BITS + THREAD_ID_BITS + 3 * PRIO_BITS + 3 + 7) / 8) * 8 - 1:0]
                                    req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [1:0] status
   output logic [1:0]               rsp_tuser,
   // write_priority, target_owner_id, new_priority, zero fill
   output logic [((1 + THREAD_ID_BITS + PRIO_BITS + 7) / 8) * 8 - 1:0]
                                    rsp_tdata
);
   import pit_pkg::*;

   localparam int RSP_W   = ((1 + THREAD_ID_BITS + PRIO_BITS + 7) / 8) * 8;
   localparam int OWN_LO  = KEY_BITS;
   localparam int OPR_LO  = OWN_LO + THREAD_ID_BITS;
   localparam int OBS_LO  = OPR_LO + PRIO_BITS;
   localparam int OTS_BIT = OBS_LO + PRIO_BITS;
   localparam int WV_BIT  = OTS_BIT + 1;
   localparam int WPR_LO  = WV_BIT + 1;
   localparam int WTS_BIT = WPR_LO + PRIO_BITS;

   ctl_cmd_type               ctl_cmd;
   ctl_sts_type               ctl_sts;
   logic                      out_write;
   logic [THREAD_ID_BITS-1:0] out_target;
   logic [PRIO_BITS-1:0]      out_prio;

   pit_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .ctl_sts   (ctl_sts),
      .ctl_cmd   (ctl_cmd)
   );

   pit_datapath #(
      .ENTRIES        (ENTRIES),
      .KEY_BITS       (KEY_BITS),
      .THREAD_ID_BITS (THREAD_ID_BITS),
      .PRIO_BITS      (PRIO_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl_cmd    (ctl_cmd),
      .ctl_sts    (ctl_sts),
      .in_cmd     (req_tuser),
      .in_key     (req_tdata[KEY_BITS-1:0]),
      .in_owner   (req_tdata[OWN_LO +: THREAD_ID_BITS]),
      .in_oprio   (req_tdata[OPR_LO +: PRIO_BITS]),
      .in_obase   (req_tdata[OBS_LO +: PRIO_BITS]),
      .in_ots     (req_tdata[OTS_BIT]),
      .in_wvalid  (req_tdata[WV_BIT]),
      .in_wprio   (req_tdata[WPR_LO +: PRIO_BITS]),
      .in_wts     (req_tdata[WTS_BIT]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (rsp_tuser),
      .out_write  (out_write),
      .out_target (out_target),
      .out_prio   (out_prio)
   );

   assign rsp_tdata = RSP_W'({out_prio, out_target, out_write});

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, ctl_cmd.out_load, !rsp_tvalid || rsp_tready)
   `ASSERT_IMPLIES(a_write_flag, clock, reset, rsp_tvalid, rsp_tdata[0] == (rsp_tuser == STATUS_WRITE))

endmodule
